// ----- src/mnxy_pkg.sv -----
// ----------------------------------------------------------------------------
// mnxy_pkg
// Shared types and constants of the mesh router step block: word layouts,
// port codes and the default mesh geometry.
// ----------------------------------------------------------------------------
package mnxy_pkg;

	localparam int unsigned DEF_MESH_ROWS        = 4;
	localparam int unsigned DEF_MESH_COLS        = 4;
	localparam int unsigned DEF_VIRTUAL_CHANNELS = 8;
	localparam int unsigned DEF_QUEUE_DEPTH      = 4;

	localparam int unsigned PORT_COUNT = 5;
	localparam int unsigned COORD_W    = 3;
	localparam int unsigned CNT_W      = 32;
	localparam int unsigned SUM_W      = 48;

	localparam logic OP_INJECT = 1'b0;
	localparam logic OP_TICK   = 1'b1;

	// Input port codes; the opposite port is the code with bit 0 flipped
	localparam logic [2:0] PORT_N = 3'd0;
	localparam logic [2:0] PORT_S = 3'd1;
	localparam logic [2:0] PORT_E = 3'd2;
	localparam logic [2:0] PORT_W = 3'd3;
	localparam logic [2:0] PORT_L = 3'd4;

	typedef struct packed {
		logic        operation;
		logic [1:0]  src_x;
		logic [1:0]  src_y;
		logic [2:0]  dst_x;
		logic [2:0]  dst_y;
		logic [2:0]  channel;
		logic [15:0] ident;
	} req_t;

	typedef struct packed {
		logic             accepted;
		logic [CNT_W-1:0] cycle_now;
		logic [CNT_W-1:0] injected_total;
		logic [CNT_W-1:0] delivered_total;
		logic [SUM_W-1:0] latency_sum;
		logic [CNT_W-1:0] latency_max;
		logic [CNT_W-1:0] dropped_total;
	} rsp_t;

	// One queue slot: destination, ident and injection stamp
	typedef struct packed {
		logic [COORD_W-1:0] dx;
		logic [COORD_W-1:0] dy;
		logic [15:0]        id;
		logic [CNT_W-1:0]   stamp;
	} slot_t;

endpackage

// ----- src/mesh_noc_xy_route_step_top.sv -----
// ----------------------------------------------------------------------------
// mesh_noc_xy_route_step_top
// Mesh network-on-chip step engine with X-then-Y routing over bounded
// per-port, per-channel queues held in on-chip memories.
// ----------------------------------------------------------------------------
// After reset the block clears the queue fill/head memory, one entry per queue
// (MESH_ROWS*MESH_COLS*5*VIRTUAL_CHANNELS entries, 640 with the defaults), and
// takes no word meanwhile. An inject word reads the target queue's control word,
// writes the slot and the new fill, then goes to the result register; a tick word
// walks every queue in order through one sequencer that shares a single read and
// a single write port on each memory: an empty queue passes the read, head and
// pop states, a delivery or edge drop adds the route state, and a stall on a full
// neighbour or a hop adds the move state as well. The memory ports set this order
// of steps. One word is in work at a time; a finished result waits in the output
// register while the next word is taken.
module mesh_noc_xy_route_step_top #(
	parameter int unsigned MESH_ROWS        = mnxy_pkg::DEF_MESH_ROWS,
	parameter int unsigned MESH_COLS        = mnxy_pkg::DEF_MESH_COLS,
	parameter int unsigned VIRTUAL_CHANNELS = mnxy_pkg::DEF_VIRTUAL_CHANNELS,
	parameter int unsigned QUEUE_DEPTH      = mnxy_pkg::DEF_QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  mnxy_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output mnxy_pkg::rsp_t rsp
);

	localparam int unsigned NODES  = MESH_ROWS * MESH_COLS;
	localparam int unsigned QCOUNT = NODES * mnxy_pkg::PORT_COUNT * VIRTUAL_CHANNELS;
	localparam int unsigned SCOUNT = QCOUNT * QUEUE_DEPTH;
	localparam int unsigned QW     = $clog2(QCOUNT);
	localparam int unsigned SW     = $clog2(SCOUNT);
	localparam int unsigned FW     = $clog2(QUEUE_DEPTH + 1);
	localparam int unsigned HW     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned VCW    = (VIRTUAL_CHANNELS > 1) ? $clog2(VIRTUAL_CHANNELS) : 1;
	localparam int unsigned CW     = mnxy_pkg::COORD_W;
	localparam int unsigned CNTW   = mnxy_pkg::CNT_W;
	localparam int unsigned SUMW   = mnxy_pkg::SUM_W;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_INJ_RD, S_INJ_WR,
		S_W_RD, S_W_HEAD, S_W_ROUTE, S_W_MOVE, S_W_POP, S_DONE
	} state_t;

	// ---------------------------------------------------------------- memories
	// Queue control memory: {fill, head} per queue; slot memory: packet slots
	logic [FW+HW-1:0]     qctl_mem [QCOUNT];
	mnxy_pkg::slot_t      slot_mem [SCOUNT];

	logic [QW-1:0]        qc_raddr, qc_waddr;
	logic                 qc_we;
	logic [FW+HW-1:0]     qc_wdata, qc_rd_q;
	logic [SW-1:0]        sl_raddr, sl_waddr;
	logic                 sl_we;
	mnxy_pkg::slot_t      sl_wdata, sl_rd_q;

	always_ff @(posedge clk) begin
		if (qc_we) begin
			qctl_mem[qc_waddr] <= qc_wdata;
		end
		qc_rd_q <= qctl_mem[qc_raddr];
	end

	always_ff @(posedge clk) begin
		if (sl_we) begin
			slot_mem[sl_waddr] <= sl_wdata;
		end
		sl_rd_q <= slot_mem[sl_raddr];
	end

	// ---------------------------------------------------------------- state
	state_t               state_q;
	logic [QW-1:0]        clr_q, cur_q, iq_q, nq_q;
	logic [CW-1:0]        x_q, y_q;
	logic [2:0]           port_q;
	logic [VCW-1:0]       vc_q;
	logic                 inj_ok_q, acc_q;
	mnxy_pkg::req_t       item_q;
	logic [FW-1:0]        fill_q;
	logic [HW-1:0]        head_q;
	mnxy_pkg::slot_t      slot_q;
	logic [CNTW-1:0]      cycle_q, inj_cnt_q, del_cnt_q, peak_q, drop_cnt_q;
	logic [SUMW-1:0]      lat_sum_q;
	logic                 rsp_valid_q;
	mnxy_pkg::rsp_t       rsp_q;

	// Split the control word read from memory
	logic [FW-1:0]        rd_fill;
	logic [HW-1:0]        rd_head;
	assign rd_fill = qc_rd_q[FW+HW-1:HW];
	assign rd_head = qc_rd_q[HW-1:0];

	// Tail slot of the queue just read: (head + fill) mod depth
	logic [FW+HW:0]       tail_sum;
	logic [HW-1:0]        rd_tail;
	always_comb begin
		tail_sum = (FW+HW+1)'(rd_head) + (FW+HW+1)'(rd_fill);
		if (tail_sum >= (FW+HW+1)'(QUEUE_DEPTH)) begin
			tail_sum = tail_sum - (FW+HW+1)'(QUEUE_DEPTH);
		end
		rd_tail = HW'(tail_sum);
	end

	// Head after a pop of the current queue
	logic [HW-1:0]        pop_head;
	assign pop_head = (head_q == HW'(QUEUE_DEPTH - 1)) ? '0 : head_q + HW'(1);

	// Inject target and its range check
	logic                 in_ok;
	logic [QW-1:0]        in_q;
	always_comb begin
		in_ok = (32'(req.src_x) < MESH_COLS) && (32'(req.src_y) < MESH_ROWS)
			&& (32'(req.channel) < VIRTUAL_CHANNELS);
		in_q = QW'((((32'(req.src_y) * MESH_COLS + 32'(req.src_x)) * mnxy_pkg::PORT_COUNT
			+ 32'(mnxy_pkg::PORT_L)) * VIRTUAL_CHANNELS) + 32'(req.channel));
	end

	// Routing decision on the head slot read in S_W_ROUTE
	logic [2:0]           dir;
	logic                 deliver, off_edge;
	logic [CW-1:0]        nx, ny;
	logic [QW-1:0]        nq;
	always_comb begin
		nx = x_q;
		ny = y_q;
		off_edge = 1'b0;
		deliver = 1'b0;
		if (x_q < sl_rd_q.dx) begin
			dir = mnxy_pkg::PORT_E;
		end else if (x_q > sl_rd_q.dx) begin
			dir = mnxy_pkg::PORT_W;
		end else if (y_q < sl_rd_q.dy) begin
			dir = mnxy_pkg::PORT_S;
		end else if (y_q > sl_rd_q.dy) begin
			dir = mnxy_pkg::PORT_N;
		end else begin
			dir = mnxy_pkg::PORT_L;
		end
		unique case (dir)
			mnxy_pkg::PORT_E: begin
				if (32'(x_q) + 1 >= MESH_COLS) off_edge = 1'b1;
				else nx = x_q + CW'(1);
			end
			mnxy_pkg::PORT_W: begin
				if (x_q == '0) off_edge = 1'b1;
				else nx = x_q - CW'(1);
			end
			mnxy_pkg::PORT_S: begin
				if (32'(y_q) + 1 >= MESH_ROWS) off_edge = 1'b1;
				else ny = y_q + CW'(1);
			end
			mnxy_pkg::PORT_N: begin
				if (y_q == '0) off_edge = 1'b1;
				else ny = y_q - CW'(1);
			end
			default: deliver = 1'b1;
		endcase
		nq = QW'((((32'(ny) * MESH_COLS + 32'(nx)) * mnxy_pkg::PORT_COUNT
			+ 32'(dir ^ 3'd1)) * VIRTUAL_CHANNELS) + 32'(vc_q));
	end

	// Latency of a delivered packet, one bit wider than the counter
	logic [CNTW:0]        lat;
	logic [SUMW:0]        sum_ext;
	assign lat     = {1'b0, cycle_q - sl_rd_q.stamp} + (CNTW+1)'(1);
	assign sum_ext = {1'b0, lat_sum_q} + (SUMW+1)'(lat);

	logic                 last_queue;
	assign last_queue = (cur_q == QW'(QCOUNT - 1));

	// ---------------------------------------------------------------- memory ports
	always_comb begin
		qc_raddr = cur_q;
		sl_raddr = SW'(32'(cur_q) * QUEUE_DEPTH + 32'(rd_head));
		qc_we    = 1'b0;
		qc_waddr = cur_q;
		qc_wdata = {FW'(fill_q - FW'(1)), pop_head};
		sl_we    = 1'b0;
		sl_waddr = SW'(32'(iq_q) * QUEUE_DEPTH + 32'(rd_tail));
		sl_wdata = slot_q;
		unique case (state_q)
			S_CLEAR: begin
				qc_we    = 1'b1;
				qc_waddr = clr_q;
				qc_wdata = '0;
			end
			S_INJ_RD: qc_raddr = iq_q;
			S_INJ_WR: begin
				if (inj_ok_q && rd_fill < FW'(QUEUE_DEPTH)) begin
					qc_we    = 1'b1;
					qc_waddr = iq_q;
					qc_wdata = {rd_fill + FW'(1), rd_head};
					sl_we    = 1'b1;
					sl_wdata.dx    = item_q.dst_x;
					sl_wdata.dy    = item_q.dst_y;
					sl_wdata.id    = item_q.ident;
					sl_wdata.stamp = cycle_q;
				end
			end
			S_W_ROUTE: begin
				qc_raddr = nq;
				qc_we    = deliver || off_edge;
			end
			S_W_MOVE: begin
				if (rd_fill < FW'(QUEUE_DEPTH)) begin
					qc_we    = 1'b1;
					qc_waddr = nq_q;
					qc_wdata = {rd_fill + FW'(1), rd_head};
					sl_we    = 1'b1;
					sl_waddr = SW'(32'(nq_q) * QUEUE_DEPTH + 32'(rd_tail));
				end
			end
			// an empty queue or a stalled head carries a zero fill: no pop
			S_W_POP: qc_we = (fill_q != '0);
			default: ;
		endcase
	end

	// ---------------------------------------------------------------- sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			cur_q       <= '0;
			iq_q        <= '0;
			nq_q        <= '0;
			x_q         <= '0;
			y_q         <= '0;
			port_q      <= '0;
			vc_q        <= '0;
			inj_ok_q    <= 1'b0;
			acc_q       <= 1'b0;
			item_q      <= '0;
			fill_q      <= '0;
			head_q      <= '0;
			slot_q      <= '0;
			cycle_q     <= '0;
			inj_cnt_q   <= '0;
			del_cnt_q   <= '0;
			lat_sum_q   <= '0;
			peak_q      <= '0;
			drop_cnt_q  <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			// drop the result once taken, unless a new one replaces it
			if (rsp_valid_q && rsp_ready && state_q != S_DONE) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + QW'(1);
					if (clr_q == QW'(QCOUNT - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_valid) begin
						item_q <= req;
						if (req.operation == mnxy_pkg::OP_TICK) begin
							cur_q   <= '0;
							x_q     <= '0;
							y_q     <= '0;
							port_q  <= '0;
							vc_q    <= '0;
							acc_q   <= 1'b1;
							state_q <= S_W_RD;
						end else begin
							inj_ok_q <= in_ok;
							iq_q     <= in_ok ? in_q : '0;
							state_q  <= S_INJ_RD;
						end
					end
				end
				S_INJ_RD: state_q <= S_INJ_WR;
				S_INJ_WR: begin
					acc_q <= inj_ok_q && rd_fill < FW'(QUEUE_DEPTH);
					if (inj_ok_q && rd_fill < FW'(QUEUE_DEPTH)) begin
						inj_cnt_q <= inj_cnt_q + CNTW'(1);
					end
					state_q <= S_DONE;
				end
				S_W_RD: state_q <= S_W_HEAD;
				S_W_HEAD: begin
					fill_q <= rd_fill;
					head_q <= rd_head;
					state_q <= (rd_fill == '0) ? S_W_POP : S_W_ROUTE;
				end
				S_W_ROUTE: begin
					slot_q <= sl_rd_q;
					nq_q   <= nq;
					if (deliver) begin
						del_cnt_q <= del_cnt_q + CNTW'(1);
						lat_sum_q <= sum_ext[SUMW] ? '1 : sum_ext[SUMW-1:0];
						if (lat > {1'b0, peak_q}) begin
							peak_q <= lat[CNTW] ? '1 : lat[CNTW-1:0];
						end
					end else if (off_edge) begin
						drop_cnt_q <= drop_cnt_q + CNTW'(1);
					end
					state_q <= (deliver || off_edge) ? S_W_POP : S_W_MOVE;
				end
				S_W_MOVE: begin
					// stall when the neighbour is full: keep the head in place
					if (rd_fill < FW'(QUEUE_DEPTH)) begin
						state_q <= S_W_POP;
					end else begin
						fill_q  <= '0;
						state_q <= S_W_POP;
					end
				end
				S_W_POP: begin
					// advance to the next queue, or close the tick
					if (last_queue) begin
						cycle_q <= cycle_q + CNTW'(1);
						state_q <= S_DONE;
					end else begin
						cur_q <= cur_q + QW'(1);
						if (vc_q == VCW'(VIRTUAL_CHANNELS - 1)) begin
							vc_q <= '0;
							if (port_q == mnxy_pkg::PORT_L) begin
								port_q <= mnxy_pkg::PORT_N;
								if (x_q == CW'(MESH_COLS - 1)) begin
									x_q <= '0;
									y_q <= y_q + CW'(1);
								end else begin
									x_q <= x_q + CW'(1);
								end
							end else begin
								port_q <= port_q + 3'd1;
							end
						end else begin
							vc_q <= vc_q + VCW'(1);
						end
						state_q <= S_W_RD;
					end
				end
				S_DONE: begin
					if (!rsp_valid_q || rsp_ready) begin
						rsp_valid_q           <= 1'b1;
						rsp_q.accepted        <= acc_q;
						rsp_q.cycle_now       <= cycle_q;
						rsp_q.injected_total  <= inj_cnt_q;
						rsp_q.delivered_total <= del_cnt_q;
						rsp_q.latency_sum     <= lat_sum_q;
						rsp_q.latency_max     <= peak_q;
						rsp_q.dropped_total   <= drop_cnt_q;
						state_q               <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ----- src/mnxy_checker.sv -----
// ----------------------------------------------------------------------------
// mnxy_checker
// Port-level checks of the mesh router step block, bound to its top level.
// ----------------------------------------------------------------------------
module mnxy_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_ready,
	input logic           rsp_valid,
	input logic           rsp_ready,
	input mnxy_pkg::rsp_t rsp
);

	// A waiting result holds still
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("result word changed while stalled");

	// An accepted word leaves the block busy in the cycle after it is taken
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("block ready straight after taking a word");

	// A new result appears together with the return to idle
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> req_ready)
		else $error("result issued while still busy");

	// Successive results never lower the cycle count and raise it by at most one tick
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_ready |=> !rsp_valid || rsp.cycle_now == $past(rsp.cycle_now)
			|| rsp.cycle_now == $past(rsp.cycle_now) + 32'd1)
		else $error("cycle count jumped between results");

endmodule

bind mesh_noc_xy_route_step_top mnxy_checker u_mnxy_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);
